FILE: sv/msu_pkg.sv
// shared types and constants of the merge sorter unit
package msu_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_START,
        ST_RUN_INIT,
        ST_READ,
        ST_MERGE,
        ST_EMIT_INIT,
        ST_EMIT_READ,
        ST_EMIT_CAP,
        ST_EMIT_WAIT
    } msu_state_t;

    typedef struct packed {
        logic load;
        logic sort_start;
        logic run_init;
        logic merge_step;
        logic next_run;
        logic next_pass;
        logic emit_init;
        logic emit_capture;
        logic emit_next;
        logic clear;
    } msu_cmd_t;

    typedef struct packed {
        logic run_last;
        logic pass_last;
        logic sort_last;
        logic trivial;
        logic emit_last;
    } msu_status_t;

endpackage

FILE: sv/msu_if.sv
// stream interfaces of the merge sorter unit
interface msu_in_if
    import msu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     is_last;

    modport source (output valid, value, is_last, input ready);
    modport sink (input valid, value, is_last, output ready);
endinterface

interface msu_out_if
    import msu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;

    modport source (output valid, sorted_value, last_out, overflow, input ready);
    modport sink (input valid, sorted_value, last_out, overflow, output ready);
endinterface

FILE: sv/msu_ctrl.sv
// controller state machine of the merge sorter unit
module msu_ctrl
    import msu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_is_last,
    output logic        in_ready,
    input  logic        out_ready,
    output logic        out_valid,
    input  msu_status_t status,
    output msu_cmd_t    cmd
);

    msu_state_t state_reg;
    msu_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_is_last)
                    begin
                        state_next = ST_SORT_START;
                    end
                end
            end
            ST_SORT_START:
            begin
                cmd.sort_start = 1'b1;
                state_next     = status.trivial ? ST_EMIT_INIT : ST_RUN_INIT;
            end
            ST_RUN_INIT:
            begin
                cmd.run_init = 1'b1;
                state_next   = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                cmd.merge_step = 1'b1;
                if (!status.run_last)
                begin
                    state_next = ST_READ;
                end
                else if (!status.pass_last)
                begin
                    cmd.next_run = 1'b1;
                    state_next   = ST_RUN_INIT;
                end
                else
                begin
                    cmd.next_pass = 1'b1;
                    state_next    = status.sort_last ? ST_EMIT_INIT : ST_RUN_INIT;
                end
            end
            ST_EMIT_INIT:
            begin
                cmd.emit_init = 1'b1;
                state_next    = ST_EMIT_READ;
            end
            ST_EMIT_READ:
            begin
                state_next = ST_EMIT_CAP;
            end
            ST_EMIT_CAP:
            begin
                cmd.emit_capture = 1'b1;
                out_valid_next   = 1'b1;
                state_next       = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (status.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EMIT_READ;
                    end
                end
            end
            default:
            begin
                state_next     = ST_LOAD;
                out_valid_next = 1'b0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_valid_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_EMIT_WAIT))
        else $error("result beat outside the wait state");

    a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid_reg))
        else $error("input taken while a result beat is pending");

    a_read_then_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_MERGE))
        else $error("merge step does not follow its read");

    a_last_beat_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && status.emit_last) |=> (state_reg == ST_LOAD))
        else $error("set not closed after its last beat");
`endif

endmodule

FILE: sv/msu_dp.sv
// datapath of the merge sorter unit: element banks, merge counters, result register
module msu_dp
    import msu_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  msu_cmd_t                 cmd,
    output msu_status_t              status,
    input  logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic                     overflow
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = AW + 2;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic signed [DATA_W-1:0] bank0_mem [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] bank1_mem [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] bank0_rd_a_reg;
    logic signed [DATA_W-1:0] bank0_rd_b_reg;
    logic signed [DATA_W-1:0] bank1_rd_a_reg;
    logic signed [DATA_W-1:0] bank1_rd_b_reg;

    logic [CW-1:0] count_reg;
    logic          dropped_reg;
    logic          src_bank_reg;
    logic [CW-1:0] width_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] mid_reg;
    logic [CW-1:0] hi_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] k_reg;

    logic signed [DATA_W-1:0] sorted_value_reg;
    logic                     last_out_reg;
    logic                     overflow_reg;

    logic signed [DATA_W-1:0] rd_a;
    logic signed [DATA_W-1:0] rd_b;
    logic                     take_a;
    logic signed [DATA_W-1:0] merge_data;
    logic [CW-1:0]            double_w;
    logic [CW-1:0]            run_mid;
    logic [CW-1:0]            run_hi;
    logic                     has_room;
    logic                     wr0_en;
    logic [AW-1:0]            wr0_addr;
    logic signed [DATA_W-1:0] wr0_data;
    logic                     wr1_en;

    assign rd_a       = src_bank_reg ? bank1_rd_a_reg : bank0_rd_a_reg;
    assign rd_b       = src_bank_reg ? bank1_rd_b_reg : bank0_rd_b_reg;
    assign take_a     = (i_reg < mid_reg) && ((j_reg >= hi_reg) || (rd_a <= rd_b));
    assign merge_data = take_a ? rd_a : rd_b;
    assign double_w   = width_reg << 1;
    assign run_mid    = ((lo_reg + width_reg) > count_reg) ? count_reg : lo_reg + width_reg;
    assign run_hi     = ((lo_reg + double_w) > count_reg) ? count_reg : lo_reg + double_w;
    assign has_room   = (count_reg < MAX_C);

    assign status.run_last  = ((k_reg + ONE_C) == hi_reg);
    assign status.pass_last = ((lo_reg + double_w) >= count_reg);
    assign status.sort_last = (double_w >= count_reg);
    assign status.trivial   = (count_reg <= ONE_C);
    assign status.emit_last = ((i_reg + ONE_C) == count_reg);

    // bank 0 takes loads and merges out of bank 1, bank 1 takes merges out of bank 0
    assign wr0_en   = (cmd.load && has_room) || (cmd.merge_step && src_bank_reg);
    assign wr0_addr = cmd.load ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign wr0_data = cmd.load ? value : merge_data;
    assign wr1_en   = cmd.merge_step && !src_bank_reg;

    always_ff @(posedge clk)
    begin
        if (wr0_en)
        begin
            bank0_mem[wr0_addr] <= wr0_data;
        end
        bank0_rd_a_reg <= bank0_mem[i_reg[AW-1:0]];
        bank0_rd_b_reg <= bank0_mem[j_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr1_en)
        begin
            bank1_mem[k_reg[AW-1:0]] <= merge_data;
        end
        bank1_rd_a_reg <= bank1_mem[i_reg[AW-1:0]];
        bank1_rd_b_reg <= bank1_mem[j_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            src_bank_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + ONE_C;
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.sort_start)
            begin
                src_bank_reg <= 1'b0;
            end
            if (cmd.next_pass)
            begin
                src_bank_reg <= !src_bank_reg;
            end
            if (cmd.clear)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_start)
        begin
            width_reg <= ONE_C;
            lo_reg    <= '0;
        end
        if (cmd.run_init)
        begin
            mid_reg <= run_mid;
            hi_reg  <= run_hi;
            i_reg   <= lo_reg;
            j_reg   <= run_mid;
            k_reg   <= lo_reg;
        end
        if (cmd.merge_step)
        begin
            k_reg <= k_reg + ONE_C;
            if (take_a)
            begin
                i_reg <= i_reg + ONE_C;
            end
            else
            begin
                j_reg <= j_reg + ONE_C;
            end
        end
        if (cmd.next_run)
        begin
            lo_reg <= lo_reg + double_w;
        end
        if (cmd.next_pass)
        begin
            width_reg <= double_w;
            lo_reg    <= '0;
        end
        if (cmd.emit_init)
        begin
            i_reg <= '0;
        end
        if (cmd.emit_next)
        begin
            i_reg <= i_reg + ONE_C;
        end
        if (cmd.emit_capture)
        begin
            sorted_value_reg <= rd_a;
            last_out_reg     <= status.emit_last;
            overflow_reg     <= dropped_reg;
        end
    end

    assign sorted_value = sorted_value_reg;
    assign last_out     = last_out_reg;
    assign overflow     = overflow_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("element count beyond capacity");

    a_merge_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_step |-> (k_reg < hi_reg) && ((i_reg < mid_reg) || (j_reg < hi_reg)))
        else $error("merge step outside its run");
`endif

endmodule

FILE: sv/merge_sorter_unit.sv
// top level of the merge sorter unit
//
// in_stream carries one signed 32-bit value per beat; is_last closes the set.
// Values beyond MAX_ELEMENTS in one set are dropped and every result of that
// set then shows overflow. A set always holds at least its first value.
// in_stream.ready is high throughout loading. After the closing beat the block sorts
// with a bottom-up stable merge sort (equal values keep arrival order) over
// two element banks used in turn: ceil(log2 n) passes, each with a setup state
// per run and a read and a merge state for the single compare and write of
// each element. out_stream then gives the n values in ascending order, each
// beat through a read, a capture and a wait state; last_out marks the final one.
// in_stream.ready stays low from the closing beat until the final result
// beat is taken. A stall on out_stream holds the current result beat and
// the sorter simply waits. Reset empties the set and drops any result in
// flight; bank contents are not cleared.
module merge_sorter_unit
    import msu_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16
)
(
    input logic       clk,
    input logic       rst_n,
    msu_in_if.sink    in_stream,
    msu_out_if.source out_stream
);

    msu_cmd_t    cmd;
    msu_status_t status;
    logic        in_ready;
    logic        out_valid;

    msu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_stream.valid),
        .in_is_last (in_stream.is_last),
        .in_ready   (in_ready),
        .out_ready  (out_stream.ready),
        .out_valid  (out_valid),
        .status     (status),
        .cmd        (cmd)
    );

    msu_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (in_stream.value),
        .sorted_value (out_stream.sorted_value),
        .last_out     (out_stream.last_out),
        .overflow     (out_stream.overflow)
    );

    assign in_stream.ready  = in_ready;
    assign out_stream.valid = out_valid;

endmodule
